FILE: hw/rtl/jbf_pkg.sv
package jbf_pkg;

    localparam int MAX_RADIUS       = 4;
    localparam int MAX_WIDTH        = 2048;
    localparam int COLOR_TABLE_SIZE = 768;

    localparam int DIAM_MAX   = 2 * MAX_RADIUS + 1;
    localparam int SPACE_SIZE = DIAM_MAX * DIAM_MAX;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SLOT_W     = $clog2(DIAM_MAX + 1);
    localparam int LINE_DEPTH = (1 << COL_W) * DIAM_MAX;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int SPACE_AW   = $clog2(SPACE_SIZE);
    localparam int COLOR_AW   = $clog2(COLOR_TABLE_SIZE);

    localparam int QUO_W  = 16;
    localparam int TW_W   = 32;
    localparam int PROD_W = QUO_W + TW_W;
    localparam int ACC_W  = PROD_W + $clog2(SPACE_SIZE);
    localparam int WSUM_W = TW_W + $clog2(SPACE_SIZE);
    localparam int NUM_W  = ACC_W + 1;

    localparam logic [1:0] MODE_PIXEL      = 2'd0;
    localparam logic [1:0] MODE_LOAD_COLOR = 2'd1;
    localparam logic [1:0] MODE_LOAD_SPACE = 2'd2;

    localparam logic [2:0] CFG_RADIUS       = 3'd0;
    localparam logic [2:0] CFG_WIDTH        = 3'd1;
    localparam logic [2:0] CFG_GUIDE_COLOR  = 3'd2;
    localparam logic [2:0] CFG_SOURCE_COLOR = 3'd3;
    localparam logic [2:0] CFG_SOURCE_FIXED = 3'd4;

endpackage

FILE: hw/rtl/jbf_ram.sv
module jbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/jbf_div.sv
module jbf_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [jbf_pkg::NUM_W-1:0]  num,
    input  logic [jbf_pkg::WSUM_W-1:0] den,
    output logic                      done,
    output logic [jbf_pkg::QUO_W-1:0]  quo
);

    localparam int DSR_W = jbf_pkg::WSUM_W + jbf_pkg::QUO_W - 1;
    localparam int CNT_W = $clog2(jbf_pkg::QUO_W + 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [jbf_pkg::NUM_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0]          dsr_reg, dsr_next;
    logic [jbf_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic                      ge;

    assign ge = rem_reg >= jbf_pkg::NUM_W'(dsr_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num;
            dsr_next  = {den, {(jbf_pkg::QUO_W - 1){1'b0}}};
            quo_next  = '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - jbf_pkg::NUM_W'(dsr_reg);
            end
            quo_next = {quo_reg[jbf_pkg::QUO_W-2:0], ge};
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(jbf_pkg::QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without a division");
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("busy after done");
`endif

endmodule

FILE: hw/rtl/joint_bilateral_filter_top.sv
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_valid / s_ready  | mode, frame_start, table_index, weight, guide, src
// m_        | out       | m_valid / m_ready  | out_c0..out_c2, out_col
// cfg_      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load request or a pixel without a full window is taken in idle and leaves s_ready high.
// A pixel with a full window then holds s_ready low through the center read and latch, the taps
// (d = 2r+1, one tap per cycle through a five-stage read and multiply-accumulate pipe), a division
// per nonzero channel (a zero channel is set to zero without the divider) and the output state.
// Reset is synchronous and active low; the line stores and weight tables are not cleared.
// A finished pixel waits in the output register while the next request is taken.
module joint_bilateral_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic        s_frame_start,
    input  logic [9:0]  s_table_index,
    input  logic [15:0] s_weight_value,
    input  logic [7:0]  s_guide_c0,
    input  logic [7:0]  s_guide_c1,
    input  logic [7:0]  s_guide_c2,
    input  logic [15:0] s_src_c0,
    input  logic [15:0] s_src_c1,
    input  logic [15:0] s_src_c2,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_c0,
    output logic [15:0] m_out_c1,
    output logic [15:0] m_out_c2,
    output logic [10:0] m_out_col,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int COL_W  = jbf_pkg::COL_W;
    localparam int SLOT_W = jbf_pkg::SLOT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CENTER = 3'd1;
    localparam logic [2:0] ST_CLATCH = 3'd2;
    localparam logic [2:0] ST_TAPS   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_WAIT   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic [2:0]  state_reg, state_next;
    logic [2:0]  radius_reg;
    logic [11:0] width_reg;
    logic        gcolor_reg, scolor_reg, sfixed_reg;

    logic [COL_W-1:0]  column_count_reg, column_count_next;
    logic [SLOT_W-1:0] row_count_reg, row_count_next;
    logic [SLOT_W-1:0] ring_slot_reg, ring_slot_next;

    logic [2:0]        r_eff;
    logic [SLOT_W-1:0] d_eff, two_r;
    logic [11:0]       w_eff;

    logic              accept, pix_acc;
    logic [SLOT_W-1:0] slot_in, row_in;
    logic [COL_W-1:0]  col_in;
    logic [11:0]       col_inc;
    logic              produce;

    logic [SLOT_W-1:0] cs_reg, cs_next;
    logic [COL_W-1:0]  base_reg, base_next;
    logic [SLOT_W:0]   crow_sum;
    logic [SLOT_W-1:0] crow;

    logic [SLOT_W-1:0] dx_reg, dx_next, dy_reg, dy_next, row_reg, row_next;
    logic [jbf_pkg::SPACE_AW-1:0] sp_reg, sp_next;
    logic [1:0]        ch_reg, ch_next;

    logic [jbf_pkg::LINE_AW-1:0] line_raddr, line_waddr;
    logic [23:0]       guide_rd;
    logic [47:0]       src_rd;
    logic [15:0]       space_rd, color_rd;
    logic [15:0]       smask;

    logic [7:0]  gc0_reg, gc1_reg, gc2_reg;
    logic        p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic [9:0]  diff;
    logic        diff_inr;
    logic [47:0] p2_src_reg, p3_src_reg;
    logic [15:0] p2_space_reg;
    logic        p2_inr_reg;
    logic [jbf_pkg::TW_W-1:0]   p3_tw_reg, p4_tw_reg;
    logic [jbf_pkg::PROD_W-1:0] p4_prod_reg [3];
    logic [jbf_pkg::ACC_W-1:0]  acc_reg [3];
    logic [jbf_pkg::WSUM_W-1:0] wsum_reg;

    logic                       div_start, div_done;
    logic [jbf_pkg::NUM_W-1:0]  div_num;
    logic [jbf_pkg::QUO_W-1:0]  div_quo;
    logic [15:0]                res_reg [3];
    logic                       ch_zero;
    logic                       res_we;
    logic [15:0]                res_val;

    logic        m_valid_reg;
    logic [15:0] m_c0_reg, m_c1_reg, m_c2_reg;
    logic [10:0] m_col_reg;

    assign r_eff = (radius_reg == 3'd0) ? 3'd1 :
                   (radius_reg > 3'(jbf_pkg::MAX_RADIUS)) ? 3'(jbf_pkg::MAX_RADIUS) : radius_reg;
    assign d_eff = {r_eff, 1'b1};
    assign two_r = {r_eff, 1'b0};
    assign w_eff = (width_reg == 12'd0) ? 12'd1 :
                   (width_reg > 12'(jbf_pkg::MAX_WIDTH)) ? 12'(jbf_pkg::MAX_WIDTH) : width_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign pix_acc   = accept && (s_mode == jbf_pkg::MODE_PIXEL);

    always_comb begin
        logic [SLOT_W-1:0] s;
        s = s_frame_start ? '0 : ring_slot_reg;
        if (s >= d_eff) begin
            s = s - d_eff;
        end
        if (s >= d_eff) begin
            s = s - d_eff;
        end
        slot_in = s;
        col_in = s_frame_start ? '0 : column_count_reg;
        if (12'(col_in) >= w_eff) begin
            col_in = '0;
        end
        row_in = s_frame_start ? '0 : row_count_reg;
        if (row_in > two_r) begin
            row_in = two_r;
        end
    end

    assign produce = (row_in >= two_r) && (col_in >= COL_W'(two_r));
    assign col_inc = 12'(col_in) + 12'd1;

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        ring_slot_next    = ring_slot_reg;
        if (pix_acc) begin
            if (col_inc >= w_eff) begin
                column_count_next = '0;
                row_count_next    = (row_in < two_r) ? row_in + 1'b1 : row_in;
                ring_slot_next    = (slot_in + 1'b1 == d_eff) ? '0 : slot_in + 1'b1;
            end else begin
                column_count_next = col_inc[COL_W-1:0];
                row_count_next    = row_in;
                ring_slot_next    = slot_in;
            end
        end
    end

    assign smask      = sfixed_reg ? 16'hFFFF : 16'h00FF;
    assign line_waddr = {slot_in, col_in};
    assign crow_sum   = {1'b0, cs_reg} + {1'b0, 1'b0, r_eff} + 1'b1;
    assign crow       = (crow_sum >= {1'b0, d_eff}) ? SLOT_W'(crow_sum - {1'b0, d_eff})
                                                    : crow_sum[SLOT_W-1:0];
    assign line_raddr = (state_reg == ST_CENTER) ? {crow, base_reg + COL_W'(r_eff)}
                                                 : {row_reg, base_reg + COL_W'(dx_reg)};

    jbf_ram #(.WIDTH(24), .DEPTH(jbf_pkg::LINE_DEPTH)) u_guide_ram (
        .aclk  (aclk),
        .we    (pix_acc),
        .waddr (line_waddr),
        .wdata ({s_guide_c2, s_guide_c1, s_guide_c0}),
        .raddr (line_raddr),
        .rdata (guide_rd)
    );

    jbf_ram #(.WIDTH(48), .DEPTH(jbf_pkg::LINE_DEPTH)) u_src_ram (
        .aclk  (aclk),
        .we    (pix_acc),
        .waddr (line_waddr),
        .wdata ({s_src_c2 & smask, s_src_c1 & smask, s_src_c0 & smask}),
        .raddr (line_raddr),
        .rdata (src_rd)
    );

    jbf_ram #(.WIDTH(16), .DEPTH(jbf_pkg::SPACE_SIZE)) u_space_ram (
        .aclk  (aclk),
        .we    (accept && s_mode == jbf_pkg::MODE_LOAD_SPACE
                && s_table_index < 10'(jbf_pkg::SPACE_SIZE)),
        .waddr (s_table_index[jbf_pkg::SPACE_AW-1:0]),
        .wdata (s_weight_value),
        .raddr (sp_reg),
        .rdata (space_rd)
    );

    assign diff = gcolor_reg ? 10'(absdiff(guide_rd[7:0], gc0_reg))
                               + 10'(absdiff(guide_rd[15:8], gc1_reg))
                               + 10'(absdiff(guide_rd[23:16], gc2_reg))
                             : 10'(absdiff(guide_rd[7:0], gc0_reg));
    assign diff_inr = diff < 10'(jbf_pkg::COLOR_TABLE_SIZE);

    jbf_ram #(.WIDTH(16), .DEPTH(jbf_pkg::COLOR_TABLE_SIZE)) u_color_ram (
        .aclk  (aclk),
        .we    (accept && s_mode == jbf_pkg::MODE_LOAD_COLOR
                && s_table_index < 10'(jbf_pkg::COLOR_TABLE_SIZE)),
        .waddr (s_table_index[jbf_pkg::COLOR_AW-1:0]),
        .wdata (s_weight_value),
        .raddr (diff[jbf_pkg::COLOR_AW-1:0]),
        .rdata (color_rd)
    );

    assign ch_zero = (wsum_reg == '0) || (ch_reg != 2'd0 && !scolor_reg);
    assign div_num = jbf_pkg::NUM_W'(acc_reg[ch_reg]) + jbf_pkg::NUM_W'(wsum_reg >> 1);
    assign div_start = (state_reg == ST_DIV) && !ch_zero;

    jbf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (wsum_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        cs_next    = cs_reg;
        base_next  = base_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        row_next   = row_reg;
        sp_next    = sp_reg;
        ch_next    = ch_reg;
        res_we     = 1'b0;
        res_val    = div_quo;
        unique case (state_reg)
            ST_IDLE: begin
                if (pix_acc && produce) begin
                    cs_next    = slot_in;
                    base_next  = col_in - COL_W'(two_r);
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER: begin
                state_next = ST_CLATCH;
            end
            ST_CLATCH: begin
                dx_next    = '0;
                dy_next    = '0;
                sp_next    = '0;
                row_next   = (cs_reg + 1'b1 == d_eff) ? '0 : cs_reg + 1'b1;
                state_next = ST_TAPS;
            end
            ST_TAPS: begin
                sp_next = sp_reg + 1'b1;
                if (dx_reg == d_eff - 1'b1) begin
                    dx_next  = '0;
                    dy_next  = dy_reg + 1'b1;
                    row_next = (row_reg + 1'b1 == d_eff) ? '0 : row_reg + 1'b1;
                    if (dy_reg == d_eff - 1'b1) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                ch_next = '0;
                if (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg && !p4_valid_reg) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (ch_zero) begin
                    res_we  = 1'b1;
                    res_val = '0;
                    ch_next = ch_reg + 1'b1;
                    if (ch_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    res_we  = 1'b1;
                    ch_next = ch_reg + 1'b1;
                    state_next = (ch_reg == 2'd2) ? ST_OUT : ST_DIV;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            radius_reg       <= 3'd1;
            width_reg        <= 12'(jbf_pkg::MAX_WIDTH);
            gcolor_reg       <= 1'b0;
            scolor_reg       <= 1'b0;
            sfixed_reg       <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            ring_slot_reg    <= '0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p3_valid_reg     <= 1'b0;
            p4_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            ring_slot_reg    <= ring_slot_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    jbf_pkg::CFG_RADIUS:       radius_reg <= cfg_data[2:0];
                    jbf_pkg::CFG_WIDTH:        width_reg  <= cfg_data;
                    jbf_pkg::CFG_GUIDE_COLOR:  gcolor_reg <= cfg_data[0];
                    jbf_pkg::CFG_SOURCE_COLOR: scolor_reg <= cfg_data[0];
                    jbf_pkg::CFG_SOURCE_FIXED: sfixed_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            p1_valid_reg <= (state_reg == ST_TAPS);
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        cs_reg   <= cs_next;
        base_reg <= base_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        row_reg  <= row_next;
        sp_reg   <= sp_next;
        ch_reg   <= ch_next;
        if (state_reg == ST_CLATCH) begin
            gc0_reg <= guide_rd[7:0];
            gc1_reg <= guide_rd[15:8];
            gc2_reg <= guide_rd[23:16];
        end
        p2_src_reg   <= src_rd;
        p2_space_reg <= space_rd;
        p2_inr_reg   <= diff_inr;
        p3_src_reg   <= p2_src_reg;
        p3_tw_reg    <= p2_space_reg * (p2_inr_reg ? color_rd : 16'd0);
        p4_tw_reg    <= p3_tw_reg;
        for (int i = 0; i < 3; i++) begin
            p4_prod_reg[i] <= p3_src_reg[16*i +: 16] * p3_tw_reg;
        end
        if (state_reg == ST_CLATCH) begin
            wsum_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (p4_valid_reg) begin
            wsum_reg <= wsum_reg + jbf_pkg::WSUM_W'(p4_tw_reg);
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= acc_reg[i] + jbf_pkg::ACC_W'(p4_prod_reg[i]);
            end
        end
        if (res_we) begin
            res_reg[ch_reg] <= res_val;
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_c0_reg  <= res_reg[0];
            m_c1_reg  <= res_reg[1];
            m_c2_reg  <= res_reg[2];
            m_col_reg <= base_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_c0  = m_c0_reg;
    assign m_out_c1  = m_c1_reg;
    assign m_out_c2  = m_c2_reg;
    assign m_out_col = m_col_reg;

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !p1_valid_reg && !p2_valid_reg && !p3_valid_reg
        && !p4_valid_reg) else $error("division started with taps in flight");
    a_tap_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAPS) |-> dx_reg < d_eff && dy_reg < d_eff && row_reg < d_eff)
        else $error("tap counter out of window");
    a_div_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_WAIT) else $error("divider result not awaited");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished pixel not presented");
`endif

endmodule
